### src/eqde_pkg.sv
package eqde_pkg;

	// Width of each event word
	localparam int WORD_W = 32;
	// One stored event: {type, payload, release tag}
	localparam int DATA_W = 3 * WORD_W;

	// Defaults for the top-level parameters
	localparam int CAPACITY_DEF    = 16;
	localparam int DISCARD_BIT_DEF = 31;

	// Request codes on the kind field
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	// One result transaction
	typedef struct packed {
		logic              ok;
		logic              evicted;
		logic [WORD_W-1:0] item_type;
		logic [WORD_W-1:0] item_payload;
		logic [WORD_W-1:0] item_release_tag;
	} res_t;

endpackage

### src/eqde_ram.sv
module eqde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/eqde_out_reg.sv
module eqde_out_reg import eqde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  res_t              res,
	output logic              load_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic              evicted,
	output logic [WORD_W-1:0] item_type,
	output logic [WORD_W-1:0] item_payload,
	output logic [WORD_W-1:0] item_release_tag
);

	logic valid_q;
	res_t data_q;

	// Slot can take a new result when empty or draining this cycle
	assign load_ok = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			data_q  <= '0;
		end else if (load && load_ok) begin
			valid_q <= 1'b1;
			data_q  <= res;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid        = valid_q;
	assign ok               = data_q.ok;
	assign evicted          = data_q.evicted;
	assign item_type        = data_q.item_type;
	assign item_payload     = data_q.item_payload;
	assign item_release_tag = data_q.item_release_tag;

endmodule

### src/eqde_ctrl.sv
module eqde_ctrl import eqde_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int DISCARD_BIT = DISCARD_BIT_DEF,
	localparam int SLOT_W = $clog2(CAPACITY),
	localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [WORD_W-1:0] event_type,
	input  logic [WORD_W-1:0] event_payload,
	input  logic [WORD_W-1:0] release_tag,
	// result to output stage
	output logic              res_valid,
	output res_t              res,
	input  logic              res_ready,
	// slot stores
	output logic [SLOT_W-1:0] rd_addr,
	input  logic [DATA_W-1:0] data_rd,
	input  logic [SLOT_W-1:0] next_rd,
	input  logic [SLOT_W-1:0] prev_rd,
	output logic              data_we,
	output logic [SLOT_W-1:0] data_waddr,
	output logic [DATA_W-1:0] data_wdata,
	output logic              next_we,
	output logic [SLOT_W-1:0] next_waddr,
	output logic [SLOT_W-1:0] next_wdata,
	output logic              prev_we,
	output logic [SLOT_W-1:0] prev_waddr,
	output logic [SLOT_W-1:0] prev_wdata
);

	localparam int DISC_POS = 2 * WORD_W + DISCARD_BIT;
	localparam int PAY_LSB  = WORD_W;
	localparam int TYPE_LSB = 2 * WORD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_WALK,
		ST_UNLINK,
		ST_LINK,
		ST_RESP
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [CAPACITY-1:0] used_q;
	logic [DATA_W-1:0] new_q;
	logic [SLOT_W-1:0] scan_q;
	logic [SLOT_W-1:0] cur_q;
	logic [SLOT_W-1:0] step_q;
	logic [SLOT_W-1:0] vic_q;
	logic [SLOT_W-1:0] p_q;
	logic [SLOT_W-1:0] n_q;
	res_t              res_q;

	logic full;
	assign full = (count_q == CNT_W'(CAPACITY));

	// Store port steering per sequencer step
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		res_valid  = (state_q == ST_RESP);
		rd_addr    = prev_rd;
		data_we    = 1'b0;
		data_waddr = scan_q;
		data_wdata = new_q;
		next_we    = 1'b0;
		next_waddr = tail_q;
		next_wdata = scan_q;
		prev_we    = 1'b0;
		prev_waddr = scan_q;
		prev_wdata = tail_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = (kind == KIND_DEQ) ? head_q : tail_q;
			end
			ST_SCAN: begin
				// append into the free slot found
				if (!used_q[scan_q]) begin
					data_we = 1'b1;
					next_we = (count_q != '0);
					prev_we = 1'b1;
				end
			end
			ST_UNLINK: begin
				next_waddr = p_q;
				next_wdata = n_q;
				next_we    = (vic_q != head_q);
				prev_waddr = n_q;
				prev_wdata = p_q;
				prev_we    = (vic_q != tail_q);
			end
			ST_LINK: begin
				// victim slot is reused for the new event at the tail
				data_we    = 1'b1;
				data_waddr = vic_q;
				next_we    = 1'b1;
				next_waddr = tail_q;
				next_wdata = vic_q;
				prev_we    = 1'b1;
				prev_waddr = vic_q;
				prev_wdata = tail_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, queue pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			used_q  <= '0;
			new_q   <= '0;
			scan_q  <= '0;
			cur_q   <= '0;
			step_q  <= '0;
			vic_q   <= '0;
			p_q     <= '0;
			n_q     <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						new_q <= {event_type, event_payload, release_tag};
						if (kind == KIND_DEQ) begin
							if (count_q == '0) begin
								res_q   <= '0;
								state_q <= ST_RESP;
							end else begin
								state_q <= ST_DEQ;
							end
						end else if (!full) begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							cur_q   <= tail_q;
							step_q  <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_DEQ: begin
					// head words are on the read port now
					res_q.ok               <= 1'b1;
					res_q.evicted          <= 1'b0;
					res_q.item_type        <= data_rd[TYPE_LSB +: WORD_W];
					res_q.item_payload     <= data_rd[PAY_LSB +: WORD_W];
					res_q.item_release_tag <= data_rd[0 +: WORD_W];
					head_q                 <= next_rd;
					used_q[head_q]         <= 1'b0;
					count_q                <= count_q - CNT_W'(1);
					state_q                <= ST_RESP;
				end
				ST_SCAN: begin
					// one used bit per cycle, lowest first
					if (!used_q[scan_q]) begin
						if (count_q == '0) begin
							head_q <= scan_q;
						end
						tail_q                 <= scan_q;
						used_q[scan_q]         <= 1'b1;
						count_q                <= count_q + CNT_W'(1);
						res_q.ok               <= 1'b1;
						res_q.evicted          <= 1'b0;
						res_q.item_type        <= '0;
						res_q.item_payload     <= '0;
						res_q.item_release_tag <= '0;
						state_q                <= ST_RESP;
					end else begin
						scan_q <= scan_q + SLOT_W'(1);
					end
				end
				ST_WALK: begin
					// one entry per cycle, tail toward head
					if (data_rd[DISC_POS]) begin
						res_q.ok               <= 1'b1;
						res_q.evicted          <= 1'b1;
						res_q.item_type        <= data_rd[TYPE_LSB +: WORD_W];
						res_q.item_payload     <= data_rd[PAY_LSB +: WORD_W];
						res_q.item_release_tag <= data_rd[0 +: WORD_W];
						vic_q                  <= cur_q;
						p_q                    <= prev_rd;
						n_q                    <= next_rd;
						state_q                <= ST_UNLINK;
					end else if (step_q == SLOT_W'(CAPACITY - 1)) begin
						res_q   <= '0;
						state_q <= ST_RESP;
					end else begin
						cur_q  <= prev_rd;
						step_q <= step_q + SLOT_W'(1);
					end
				end
				ST_UNLINK: begin
					if (vic_q == head_q) begin
						head_q <= n_q;
					end
					if (vic_q == tail_q) begin
						tail_q <= p_q;
					end
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					tail_q  <= vic_q;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

### src/event_queue_with_discard_eviction_core.sv
// Bounded event queue with eviction of discardable entries.
// Input channel (in_valid/in_ready) carries one request transaction: kind selects
// enqueue of {event_type, event_payload, release_tag} or dequeue of the oldest event.
// Output channel (out_valid/out_ready) returns exactly one result per request:
// ok, evicted and the three item words (dequeued event or evicted victim).
// A full-queue enqueue walks from the newest entry toward the oldest for one whose
// type has bit DISCARD_BIT set; that entry is dropped and reported, else the
// request is rejected with ok low.
// A dequeue reads the head slot; an enqueue with room scans the used bits from the
// lowest slot for a free one; a full enqueue walks up to CAPACITY entries, then
// unlinks the victim and links the new event at the tail.
// The sequencer steps one slot per cycle through the registered-read slot stores.
// One request is in flight at a time: in_ready is high only while the sequencer is
// idle, so a new request is taken only after the last result has left the sequencer.
// A stalled receiver holds the result in the output register; the sequencer
// holds its result until that register can take it, then returns to idle.
// Reset (arst_n low) empties the queue; slot contents need no clearing.
module event_queue_with_discard_eviction_core import eqde_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int DISCARD_BIT = DISCARD_BIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [WORD_W-1:0] event_type,
	input  logic [WORD_W-1:0] event_payload,
	input  logic [WORD_W-1:0] release_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic              evicted,
	output logic [WORD_W-1:0] item_type,
	output logic [WORD_W-1:0] item_payload,
	output logic [WORD_W-1:0] item_release_tag
);

	localparam int SLOT_W = $clog2(CAPACITY);

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic [SLOT_W-1:0] rd_addr;
	logic [DATA_W-1:0] data_rd;
	logic [SLOT_W-1:0] next_rd;
	logic [SLOT_W-1:0] prev_rd;
	logic              data_we;
	logic [SLOT_W-1:0] data_waddr;
	logic [DATA_W-1:0] data_wdata;
	logic              next_we;
	logic [SLOT_W-1:0] next_waddr;
	logic [SLOT_W-1:0] next_wdata;
	logic              prev_we;
	logic [SLOT_W-1:0] prev_waddr;
	logic [SLOT_W-1:0] prev_wdata;

	// Sequencer and queue bookkeeping
	eqde_ctrl #(
		.CAPACITY    (CAPACITY),
		.DISCARD_BIT (DISCARD_BIT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.event_type    (event_type),
		.event_payload (event_payload),
		.release_tag   (release_tag),
		.res_valid     (res_valid),
		.res           (res),
		.res_ready     (res_ready),
		.rd_addr       (rd_addr),
		.data_rd       (data_rd),
		.next_rd       (next_rd),
		.prev_rd       (prev_rd),
		.data_we       (data_we),
		.data_waddr    (data_waddr),
		.data_wdata    (data_wdata),
		.next_we       (next_we),
		.next_waddr    (next_waddr),
		.next_wdata    (next_wdata),
		.prev_we       (prev_we),
		.prev_waddr    (prev_waddr),
		.prev_wdata    (prev_wdata)
	);

	// Event words per slot
	eqde_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.raddr (rd_addr),
		.rdata (data_rd)
	);

	// Forward links (toward newer entries)
	eqde_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (CAPACITY)
	) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (rd_addr),
		.rdata (next_rd)
	);

	// Backward links (toward older entries)
	eqde_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (CAPACITY)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (rd_addr),
		.rdata (prev_rd)
	);

	// Result register toward the receiver
	eqde_out_reg u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (res_valid),
		.res              (res),
		.load_ok          (res_ready),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ok               (ok),
		.evicted          (evicted),
		.item_type        (item_type),
		.item_payload     (item_payload),
		.item_release_tag (item_release_tag)
	);

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
	import eqde_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int DISCARD_BIT = DISCARD_BIT_DEF;
	localparam int HALF_PERIOD = 5;

	// One stored event and one request transaction
	typedef struct packed {
		logic [WORD_W-1:0] etype;
		logic [WORD_W-1:0] payload;
		logic [WORD_W-1:0] tag;
	} event_t;

	typedef struct packed {
		logic   kind;
		event_t ev;
	} request_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              kind = KIND_ENQ;
	logic [WORD_W-1:0] event_type = '0;
	logic [WORD_W-1:0] event_payload = '0;
	logic [WORD_W-1:0] release_tag = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              ok;
	logic              evicted;
	logic [WORD_W-1:0] item_type;
	logic [WORD_W-1:0] item_payload;
	logic [WORD_W-1:0] item_release_tag;

	request_t request_queue[$];
	res_t     expected_results[$];
	event_t   queued_events[$];
	int       mismatch_count = 0;

	event_queue_with_discard_eviction_core #(
		.CAPACITY(CAPACITY),
		.DISCARD_BIT(DISCARD_BIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.event_type(event_type),
		.event_payload(event_payload),
		.release_tag(release_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.evicted(evicted),
		.item_type(item_type),
		.item_payload(item_payload),
		.item_release_tag(item_release_tag)
	);

	always #HALF_PERIOD clk = ~clk;

	// Queue behavior: FIFO order, newest discardable entry dropped when full
	function automatic res_t apply_queue_op(request_t r);
		res_t res;
		int   victim;
		res = '0;
		victim = -1;
		if (r.kind == KIND_DEQ) begin
			if (queued_events.size() > 0) begin
				res.ok = 1'b1;
				res.item_type = queued_events[0].etype;
				res.item_payload = queued_events[0].payload;
				res.item_release_tag = queued_events[0].tag;
				void'(queued_events.pop_front());
			end
		end else if (queued_events.size() < CAPACITY) begin
			queued_events.push_back(r.ev);
			res.ok = 1'b1;
		end else begin
			for (int i = queued_events.size() - 1; i >= 0; i--) begin
				if (queued_events[i].etype[DISCARD_BIT]) begin
					victim = i;
					break;
				end
			end
			if (victim >= 0) begin
				res.ok = 1'b1;
				res.evicted = 1'b1;
				res.item_type = queued_events[victim].etype;
				res.item_payload = queued_events[victim].payload;
				res.item_release_tag = queued_events[victim].tag;
				queued_events.delete(victim);
				queued_events.push_back(r.ev);
			end
		end
		return res;
	endfunction

	task automatic add_request(logic k, logic [WORD_W-1:0] t, logic [WORD_W-1:0] p,
		logic [WORD_W-1:0] g);
		request_t r;
		r.kind = k;
		r.ev.etype = t;
		r.ev.payload = p;
		r.ev.tag = g;
		request_queue.push_back(r);
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] exp_v,
		logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ERROR %s mismatch: expected %h actual %h", $time, name,
				exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Driver: bursts of transactions separated by random gaps
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid && in_ready) begin
				nxt.kind = kind;
				nxt.ev.etype = event_type;
				nxt.ev.payload = event_payload;
				nxt.ev.tag = release_tag;
				expected_results.push_back(apply_queue_op(nxt));
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				nxt = request_queue.pop_front();
				in_valid <= 1'b1;
				kind <= nxt.kind;
				event_type <= nxt.ev.etype;
				event_payload <= nxt.ev.payload;
				release_tag <= nxt.ev.tag;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern, reloaded periodically with a new random one
	logic [15:0] stall_pattern = 16'hFFFF;
	int          pattern_age = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (pattern_age == 63) begin
				pattern_age = 0;
				case ($urandom_range(0, 2))
					0: stall_pattern = 16'hFFFF;
					1: stall_pattern = 16'($urandom);
					default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end else begin
				pattern_age++;
				stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			end
			out_ready <= stall_pattern[0];
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t ERROR result with no request outstanding: ok %b evicted %b",
					$time, ok, evicted);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("ok", WORD_W'(exp_r.ok), WORD_W'(ok));
				check_field("evicted", WORD_W'(exp_r.evicted), WORD_W'(evicted));
				check_field("item_type", exp_r.item_type, item_type);
				check_field("item_payload", exp_r.item_payload, item_payload);
				check_field("item_release_tag", exp_r.item_release_tag, item_release_tag);
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] non_discard;
		int                n_rand;
		int                phase_len;
		int                enq_pct;
		int                disc_pct;

		non_discard = ~(32'h1 << DISCARD_BIT);

		// Dequeue from an empty queue
		add_request(KIND_DEQ, $urandom, $urandom, $urandom);
		// Fill the queue; only one entry is discardable
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 5)
				t = '1;
			else if (i == 0)
				t = '0;
			else
				t = $urandom & non_discard;
			add_request(KIND_ENQ, t,
				(i == 0) ? '0 : (i == CAPACITY - 1) ? '1 : $urandom,
				(i == 0) ? '0 : (i == CAPACITY - 1) ? '1 : $urandom);
		end
		// Full with a victim, then full with none left
		add_request(KIND_ENQ, 32'h0, '1, '1);
		add_request(KIND_ENQ, $urandom & non_discard, $urandom, $urandom);
		for (int i = 0; i < 4; i++)
			add_request(KIND_DEQ, $urandom, $urandom, $urandom);

		// Random phases with varying fill pressure and discard density
		n_rand = 0;
		while (n_rand < 400) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 3))
				0: enq_pct = 30;
				1: enq_pct = 50;
				2: enq_pct = 75;
				default: enq_pct = 95;
			endcase
			case ($urandom_range(0, 3))
				0: disc_pct = 0;
				1: disc_pct = 10;
				2: disc_pct = 50;
				default: disc_pct = 100;
			endcase
			for (int i = 0; i < phase_len; i++) begin
				t = $urandom;
				t[DISCARD_BIT] = ($urandom_range(0, 99) < disc_pct);
				add_request(($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ,
					t, $urandom, $urandom);
			end
			n_rand += phase_len;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (request_queue.size() != 0 || in_valid);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
src/eqde_pkg.sv
src/eqde_ram.sv
src/eqde_out_reg.sv
src/eqde_ctrl.sv
src/event_queue_with_discard_eviction_core.sv
test/tb.sv
